// ===== rtl/core/dwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_pkg
// Shared types, field widths and codes of the DNA window minimizer.
// ----------------------------------------------------------------------------
package dwm_pkg;

    // Default sizes of the block
    localparam int KMER_LEN_DEF    = 15;
    localparam int WINDOW_LEN_DEF  = 10;
    localparam int MAX_RECORDS_DEF = 2046;

    // Field widths
    localparam int KIND_W         = 2;
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 24;
    localparam int PAYLOAD_W      = 23;
    localparam int KMER_OUT_W     = 30;
    localparam int COUNT_W        = 11;
    localparam int BASE_IDX_W     = 25;
    localparam int SELECT_W       = 16;
    localparam int PASS_BITS_W    = 5;
    localparam int HASH_W         = 32;
    localparam int SHIFT_W        = 6;
    localparam int BASE_W         = 2;
    localparam int BASES_PER_BYTE = 4;
    localparam int BASE_CNT_W     = 3;
    localparam int BUF_IDX_W      = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 23;

    // Constants
    localparam logic [HASH_W-1:0]    GOLDEN_MUL     = 32'h9E37_79B9;
    localparam logic [BASE_W-1:0]    BASE_MASK      = 2'b11;
    localparam logic [PAYLOAD_W-1:0] CAPACITY_RESET = 23'd4194304;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // Result kinds
    localparam logic RK_RECORD = 1'b0;
    localparam logic RK_COUNT  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_BITS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [POS_W-1:0]     owned_offset;
        logic [PAYLOAD_W-1:0] payload_bytes;
    } dwm_in_t;

    typedef struct packed {
        logic                  result_kind;
        logic [KMER_OUT_W-1:0] canonical_kmer;
        logic [POS_W-1:0]      kmer_position;
        logic [COUNT_W-1:0]    record_count;
        logic                  last;
    } dwm_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic base_step;
        logic scan_step;
        logic hash;
        logic judge;
        logic pop;
        logic show_count;
    } dwm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic              bytes_left_zero;
        logic              base_scan;
        logic              base_cand;
        logic              last_base;
        logic              bases_done;
        logic              scan_last;
        logic              buf_empty;
        logic              rd_last;
    } dwm_status_t;

endpackage

// ===== rtl/core/dwm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_datapath
// Rolling k-mers, window ring, minimum tracking, hash filter, record buffer
// and configuration registers of the DNA window minimizer.
// ----------------------------------------------------------------------------
module dwm_datapath
    import dwm_pkg::*;
#(
    parameter int KMER_LEN    = KMER_LEN_DEF,
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dwm_in_t                s_data,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  dwm_cmd_t               cmd,
    output dwm_status_t            status,
    output dwm_out_t               m_data
);

    localparam int KW     = 2 * KMER_LEN;
    localparam int RUN_W  = $clog2(KMER_LEN + 1);
    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int REC_W  = $clog2(MAX_RECORDS + 1);

    localparam logic [RUN_W-1:0]      RUN_FULL   = RUN_W'(KMER_LEN);
    localparam logic [RUN_W-1:0]      RUN_ALMOST = RUN_W'(KMER_LEN - 1);
    localparam logic [SLOT_W-1:0]     LAST_SLOT  = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(WINDOW_LEN);
    localparam logic [BASE_IDX_W-1:0] START_BACK = BASE_IDX_W'(KMER_LEN - 1);
    localparam logic [REC_W-1:0]      REC_MAX    = REC_W'(MAX_RECORDS);
    localparam logic [BASE_CNT_W-1:0] BASES_ALL  = BASE_CNT_W'(BASES_PER_BYTE);

    // Configuration
    logic [SELECT_W-1:0]    pass_select_reg, pass_select_next;
    logic [PASS_BITS_W-1:0] pass_bits_reg, pass_bits_next;
    logic [PAYLOAD_W-1:0]   capacity_reg, capacity_next;

    // Per-chunk state
    logic [KW-1:0]         fwd_reg, fwd_next;
    logic [KW-1:0]         rc_reg, rc_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [SLOT_W-1:0]     next_slot_reg, next_slot_next;
    logic [KW-1:0]         min_val_reg, min_val_next;
    logic [POS_W-1:0]      min_start_reg, min_start_next;
    logic [SLOT_W-1:0]     min_slot_reg, min_slot_next;
    logic                  min_known_reg, min_known_next;
    logic [BASE_IDX_W-1:0] base_index_reg, base_index_next;
    logic [REC_W-1:0]      emitted_reg, emitted_next;
    logic [POS_W-1:0]      owned_reg, owned_next;
    logic [PAYLOAD_W-1:0]  bytes_left_reg, bytes_left_next;

    // Per-item sequencing
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [BASE_CNT_W-1:0] base_cnt_reg, base_cnt_next;
    logic [SLOT_W-1:0]     scan_slot_reg, scan_slot_next;
    logic [SLOT_W-1:0]     scan_off_reg, scan_off_next;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [BASE_CNT_W-1:0] buf_n_reg, buf_n_next;
    logic [BUF_IDX_W-1:0]  rd_reg, rd_next;

    // Window ring and record buffer
    logic [KW-1:0]    ring_val_reg   [WINDOW_LEN];
    logic [POS_W-1:0] ring_start_reg [WINDOW_LEN];
    logic [KW-1:0]    buf_val_reg    [BASES_PER_BYTE];
    logic [POS_W-1:0] buf_pos_reg    [BASES_PER_BYTE];
    logic             ring_we;
    logic             buf_we;

    // Base step terms
    logic [BASE_W-1:0]    base;
    logic [KW-1:0]        fwd_step;
    logic [KW-1:0]        rc_step;
    logic [KW-1:0]        canon;
    logic [POS_W-1:0]     start_pos;
    logic [SLOT_W-1:0]    slot_after;
    logic                 kmer_full;
    logic                 filling;
    logic                 scan_now;
    logic                 improve;
    logic [PAYLOAD_W-1:0] announced;

    // Scan and filter terms
    logic [KW-1:0]      scan_val;
    logic [SHIFT_W-1:0] shamt;
    logic [HASH_W-1:0]  slice;
    logic               slice_ok;
    logic               keep;

    // Roll one base into both k-mers
    assign base      = BASE_W'(byte_reg >> {~base_cnt_reg[1:0], 1'b0}) & BASE_MASK;
    assign fwd_step  = (fwd_reg << 2) | KW'(base);
    assign rc_step   = (rc_reg >> 2) | (KW'(base ^ BASE_MASK) << (KW - 2));
    assign canon     = (fwd_step < rc_step) ? fwd_step : rc_step;
    assign start_pos = POS_W'(base_index_reg - START_BACK);
    assign slot_after = (next_slot_reg == LAST_SLOT) ? '0 : next_slot_reg + SLOT_W'(1);
    assign kmer_full = (run_reg >= RUN_ALMOST);

    // Decide between first fill, rescan and strict improvement
    assign filling  = (fill_reg < FILL_FULL);
    assign scan_now = filling ? (fill_reg + FILL_W'(1) == FILL_FULL)
                              : (min_known_reg && (next_slot_reg == min_slot_reg));
    assign improve  = !filling && !scan_now && min_known_reg && (canon < min_val_reg);

    // Slice filter on the hashed position
    assign scan_val = ring_val_reg[scan_slot_reg];
    assign shamt    = SHIFT_W'(HASH_W) - SHIFT_W'(pass_bits_reg);
    assign slice    = hash_reg >> shamt;
    assign slice_ok = (pass_bits_reg == '0) || (slice == HASH_W'(pass_select_reg));
    assign keep     = (min_start_reg >= owned_reg) && slice_ok && (emitted_reg < REC_MAX);

    assign announced = (s_data.payload_bytes < capacity_reg) ? s_data.payload_bytes
                                                             : capacity_reg;

    // Status toward the controller
    always_comb begin
        status.in_kind         = s_data.kind;
        status.bytes_left_zero = (bytes_left_reg == '0);
        status.base_scan       = kmer_full && scan_now;
        status.base_cand       = kmer_full && improve;
        status.last_base       = (base_cnt_reg == BASES_ALL - BASE_CNT_W'(1));
        status.bases_done      = (base_cnt_reg == BASES_ALL);
        status.scan_last       = (scan_off_reg == LAST_SLOT);
        status.buf_empty       = (buf_n_reg == '0);
        status.rd_last         = ({1'b0, rd_reg} == buf_n_reg - BASE_CNT_W'(1));
    end

    // Next-state logic
    always_comb begin
        pass_select_next = pass_select_reg;
        pass_bits_next   = pass_bits_reg;
        capacity_next    = capacity_reg;
        fwd_next         = fwd_reg;
        rc_next          = rc_reg;
        run_next         = run_reg;
        fill_next        = fill_reg;
        next_slot_next   = next_slot_reg;
        min_val_next     = min_val_reg;
        min_start_next   = min_start_reg;
        min_slot_next    = min_slot_reg;
        min_known_next   = min_known_reg;
        base_index_next  = base_index_reg;
        emitted_next     = emitted_reg;
        owned_next       = owned_reg;
        bytes_left_next  = bytes_left_reg;
        byte_next        = byte_reg;
        base_cnt_next    = base_cnt_reg;
        scan_slot_next   = scan_slot_reg;
        scan_off_next    = scan_off_reg;
        hash_next        = hash_reg;
        buf_n_next       = buf_n_reg;
        rd_next          = rd_reg;
        ring_we          = 1'b0;
        buf_we           = 1'b0;

        // Register writes
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PASS_SELECT: pass_select_next = cfg_data[SELECT_W-1:0];
                CFG_PASS_BITS:   pass_bits_next   = cfg_data[PASS_BITS_W-1:0];
                CFG_CAPACITY:    capacity_next    = cfg_data[PAYLOAD_W-1:0];
                default: ;
            endcase
        end

        // Take an input transfer
        if (cmd.accept) begin
            case (s_data.kind)
                KIND_START: begin
                    fwd_next        = '0;
                    rc_next         = '0;
                    run_next        = '0;
                    fill_next       = '0;
                    next_slot_next  = '0;
                    min_val_next    = '0;
                    min_start_next  = '0;
                    min_slot_next   = '0;
                    min_known_next  = 1'b0;
                    base_index_next = '0;
                    emitted_next    = '0;
                    owned_next      = s_data.owned_offset;
                    bytes_left_next = announced;
                end
                KIND_DATA: begin
                    if (bytes_left_reg != '0) begin
                        bytes_left_next = bytes_left_reg - PAYLOAD_W'(1);
                        byte_next       = s_data.data_byte;
                        base_cnt_next   = '0;
                        buf_n_next      = '0;
                        rd_next         = '0;
                    end
                end
                default: ;
            endcase
        end

        // Advance one base
        if (cmd.base_step) begin
            base_index_next = base_index_reg + BASE_IDX_W'(1);
            fwd_next        = fwd_step;
            rc_next         = rc_step;
            base_cnt_next   = base_cnt_reg + BASE_CNT_W'(1);
            if (run_reg < RUN_FULL) begin
                run_next = run_reg + RUN_W'(1);
            end
            if (kmer_full) begin
                ring_we        = 1'b1;
                next_slot_next = slot_after;
                if (filling) begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                if (scan_now) begin
                    scan_slot_next = slot_after;
                    scan_off_next  = '0;
                end else if (improve) begin
                    min_val_next   = canon;
                    min_start_next = start_pos;
                    min_slot_next  = next_slot_reg;
                end
            end
        end

        // Walk the ring from the oldest slot; oldest wins on ties
        if (cmd.scan_step) begin
            if ((scan_off_reg == '0) || (scan_val < min_val_reg)) begin
                min_val_next   = scan_val;
                min_start_next = ring_start_reg[scan_slot_reg];
                min_slot_next  = scan_slot_reg;
            end
            scan_slot_next = (scan_slot_reg == LAST_SLOT) ? '0
                                                          : scan_slot_reg + SLOT_W'(1);
            scan_off_next  = scan_off_reg + SLOT_W'(1);
            min_known_next = 1'b1;
        end

        // Hash the candidate position
        if (cmd.hash) begin
            hash_next = HASH_W'(HASH_W'(min_start_reg) * GOLDEN_MUL);
        end

        // Keep or drop the candidate
        if (cmd.judge && keep) begin
            buf_we       = 1'b1;
            emitted_next = emitted_reg + REC_W'(1);
            buf_n_next   = buf_n_reg + BASE_CNT_W'(1);
        end

        if (cmd.pop) begin
            rd_next = rd_reg + BUF_IDX_W'(1);
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_select_reg <= '0;
            pass_bits_reg   <= '0;
            capacity_reg    <= CAPACITY_RESET;
            fwd_reg         <= '0;
            rc_reg          <= '0;
            run_reg         <= '0;
            fill_reg        <= '0;
            next_slot_reg   <= '0;
            min_val_reg     <= '0;
            min_start_reg   <= '0;
            min_slot_reg    <= '0;
            min_known_reg   <= 1'b0;
            base_index_reg  <= '0;
            emitted_reg     <= '0;
            owned_reg       <= '0;
            bytes_left_reg  <= '0;
            base_cnt_reg    <= '0;
            scan_slot_reg   <= '0;
            scan_off_reg    <= '0;
            buf_n_reg       <= '0;
            rd_reg          <= '0;
        end else begin
            pass_select_reg <= pass_select_next;
            pass_bits_reg   <= pass_bits_next;
            capacity_reg    <= capacity_next;
            fwd_reg         <= fwd_next;
            rc_reg          <= rc_next;
            run_reg         <= run_next;
            fill_reg        <= fill_next;
            next_slot_reg   <= next_slot_next;
            min_val_reg     <= min_val_next;
            min_start_reg   <= min_start_next;
            min_slot_reg    <= min_slot_next;
            min_known_reg   <= min_known_next;
            base_index_reg  <= base_index_next;
            emitted_reg     <= emitted_next;
            owned_reg       <= owned_next;
            bytes_left_reg  <= bytes_left_next;
            base_cnt_reg    <= base_cnt_next;
            scan_slot_reg   <= scan_slot_next;
            scan_off_reg    <= scan_off_next;
            buf_n_reg       <= buf_n_next;
            rd_reg          <= rd_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        hash_reg <= hash_next;
        if (ring_we) begin
            ring_val_reg[next_slot_reg]   <= canon;
            ring_start_reg[next_slot_reg] <= start_pos;
        end
        if (buf_we) begin
            buf_val_reg[buf_n_reg[BUF_IDX_W-1:0]] <= min_val_reg;
            buf_pos_reg[buf_n_reg[BUF_IDX_W-1:0]] <= min_start_reg;
        end
    end

    // Result payload
    always_comb begin
        m_data = '0;
        if (cmd.show_count) begin
            m_data.result_kind  = RK_COUNT;
            m_data.record_count = COUNT_W'(emitted_reg);
            m_data.last         = 1'b1;
        end else begin
            m_data.result_kind    = RK_RECORD;
            m_data.canonical_kmer = KMER_OUT_W'(buf_val_reg[rd_reg]);
            m_data.kmer_position  = buf_pos_reg[rd_reg];
            m_data.last           = status.rd_last;
        end
    end

endmodule

// ===== rtl/core/dwm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_ctrl
// Sequencer of the DNA window minimizer: accept, per-base steps, ring scan,
// filter and drain of the records of one item, and the count at chunk end.
// ----------------------------------------------------------------------------
module dwm_ctrl
    import dwm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  dwm_status_t status,
    output dwm_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BASE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_HASH  = 7'b0001000,
        S_JUDGE = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_COUNT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.in_kind == KIND_END) begin
                        state_next = S_COUNT;
                    end else if (status.in_kind == KIND_DATA && !status.bytes_left_zero) begin
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE: begin
                cmd.base_step = 1'b1;
                if (status.base_scan) begin
                    state_next = S_SCAN;
                end else if (status.base_cand) begin
                    state_next = S_HASH;
                end else if (status.last_base) begin
                    state_next = S_DRAIN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash   = 1'b1;
                state_next = S_JUDGE;
            end
            S_JUDGE: begin
                cmd.judge  = 1'b1;
                state_next = status.bases_done ? S_DRAIN : S_BASE;
            end
            S_DRAIN: begin
                if (status.buf_empty) begin
                    state_next = S_IDLE;
                end else begin
                    m_valid = 1'b1;
                    if (m_ready) begin
                        cmd.pop = 1'b1;
                        if (status.rd_last) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_COUNT: begin
                m_valid        = 1'b1;
                cmd.show_count = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/dna_window_minimizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_window_minimizer
// Canonical k-mer window minimizer over 2-bit packed DNA, four bases a byte.
// ----------------------------------------------------------------------------
// One item at a time. A chunk-start item is only accepted; a chunk-end item
// is accepted and then answered by the count transfer. A data byte is accepted,
// then its four bases are stepped in turn, each candidate minimum adds a hash
// multiply and then the filter, and each ring rescan walks the ring one slot a
// cycle from the oldest entry. Its records are then sent one per transfer, or the
// drain state passes idle when the byte gave no record. Records of one byte
// collect in a four-entry buffer so the final one carries last. The
// configuration port always takes writes; write it only while idle.
// ----------------------------------------------------------------------------
module dna_window_minimizer
    import dwm_pkg::*;
#(
    parameter int KMER_LEN    = KMER_LEN_DEF,
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dwm_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output dwm_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dwm_cmd_t    cmd;
    dwm_status_t status;

    assign cfg_ready = 1'b1;

    dwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dwm_datapath #(
        .KMER_LEN    (KMER_LEN),
        .WINDOW_LEN  (WINDOW_LEN),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/dwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_checker
// Port-level checks of the DNA window minimizer, bound to the top level.
// ----------------------------------------------------------------------------
module dwm_checker
    import dwm_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input dwm_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input dwm_out_t m_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Never take input while a result is pending
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    // Chunk end answers with a count in the next cycle
    a_end_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_END)
        |=> m_valid && (m_data.result_kind == RK_COUNT))
        else $error("chunk end without count result");

    // Count result is alone and clean
    a_count_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == RK_COUNT)
        |-> m_data.last && (m_data.canonical_kmer == '0) && (m_data.kmer_position == '0))
        else $error("malformed count result");

    // Record carries no count
    a_record_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == RK_RECORD) |-> (m_data.record_count == '0))
        else $error("record with nonzero count");

endmodule

bind dna_window_minimizer dwm_checker u_dwm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
